// ===== rtl/ccw_pkg.sv =====
// shared widths, latencies and register indexes of the capsule contact weighting block
// used by every module under rtl
package ccw_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int LEG_W      = 33;
  localparam int PEN_W      = 32;
  localparam int SQ_W       = 66;
  localparam int DOT_W      = 65;
  localparam int LEN_W      = 33;
  localparam int SQRT_REM_W = 37;
  localparam int EPS_W      = 16;
  localparam int DIV_W      = 34;
  localparam int DREM_W     = 35;
  localparam int RAW_W      = 98;
  localparam int NREM_W     = 99;
  localparam int WGT_W      = 17;
  localparam int MASSIN_W   = 32;
  localparam int MPROD_W    = 49;
  localparam int MSUM_W     = 50;
  localparam int MASS_W     = 33;
  localparam int CFG_IDX_W  = 2;

  localparam int LANE_LAT   = 5 + LEN_W;
  localparam int RAW_LAT    = 2 + RAW_W;
  localparam int MERGE_LAT  = 4 + WGT_W;
  localparam int PIPE_LAT   = LANE_LAT + RAW_LAT + MERGE_LAT;

  localparam logic [CFG_IDX_W-1:0] REG_START_MASS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MASS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 2'd2;

  localparam logic [WGT_W-1:0]    WGT_ONE  = WGT_W'(1) << FRAC_BITS;
  localparam logic [MASS_W-1:0]   MASS_MAX = '1;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ===== rtl/capsule_contact_weighting.sv =====
// capsule contact weighting: endpoint weights and effective mass per contact.
// one contact per cycle sustained while the skid entry is empty and s_tready stays high.
// the depth is set by the 33-stage square root, the 98-stage raw weight divider and the
// 17-stage normalizing divider; an output register with a skid entry holds results.
// rst clears all valids and restores start_mass, end_mass to 1.0 and epsilon to one ulp.
module capsule_contact_weighting import ccw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, contact_x, contact_y, contact_z,
  // pen_x, pen_y, pen_z: 32 bits each from bit 0 up
  input  logic [383:0]         s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // start_weight [16:0], end_weight [33:17], effective_mass [66:34], zeros [71:67]
  output logic [71:0]          m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [MASSIN_W-1:0] start_mass;
  logic [MASSIN_W-1:0] end_mass;
  logic [EPS_W-1:0]    epsilon;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_mass <= MASSIN_W'(1) << FRAC_BITS;
      end_mass   <= MASSIN_W'(1) << FRAC_BITS;
      epsilon    <= EPS_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_MASS: start_mass <= cfg_data;
        REG_END_MASS:   end_mass   <= cfg_data;
        REG_EPSILON:    epsilon    <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  coord_t st [3];
  coord_t ed [3];
  coord_t ct [3];
  coord_t pn [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      st[k] = s_tdata[COORD_W*k +: COORD_W];
      ed[k] = s_tdata[COORD_W*(3+k) +: COORD_W];
      ct[k] = s_tdata[COORD_W*(6+k) +: COORD_W];
      pn[k] = s_tdata[COORD_W*(9+k) +: COORD_W];
    end
  end

  // whole pipeline advances unless the skid entry is taken
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign s_tready = en;

  logic [PIPE_LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], s_tvalid};
    end
  end

  logic [LEN_W-1:0] len_s;
  logic [LEN_W-1:0] len_e;
  logic [DOT_W-1:0] dot_s;
  logic [DOT_W-1:0] dot_e;
  logic [RAW_W-1:0] cs;
  logic [RAW_W-1:0] ce;

  ccw_lane u_lane_s (.clk(clk), .en(en), .pt(st), .ctr(ct), .pen(pn),
                     .len(len_s), .absdot(dot_s));
  ccw_lane u_lane_e (.clk(clk), .en(en), .pt(ed), .ctr(ct), .pen(pn),
                     .len(len_e), .absdot(dot_e));

  ccw_rawdiv u_raw_s (.clk(clk), .en(en), .absdot(dot_s), .other_len(len_e),
                      .own_len(len_s), .eps(epsilon), .raw(cs));
  ccw_rawdiv u_raw_e (.clk(clk), .en(en), .absdot(dot_e), .other_len(len_s),
                      .own_len(len_e), .eps(epsilon), .raw(ce));

  logic [WGT_W-1:0]  pw_s;
  logic [WGT_W-1:0]  pw_e;
  logic [MASS_W-1:0] pmass;

  ccw_merge u_merge (
    .clk(clk), .en(en), .cs(cs), .ce(ce), .eps(epsilon),
    .start_mass(start_mass), .end_mass(end_mass),
    .start_weight(pw_s), .end_weight(pw_e), .effective_mass(pmass)
  );

  logic [71:0] pdata;
  logic [71:0] out_data;
  logic [71:0] skid_data;
  logic        out_valid;
  logic        pv;

  assign pdata = {5'b0, pmass, pw_e, pw_s};
  assign pv    = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pv;
      end
    end else if (pv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_data <= skid_valid ? skid_data : pdata;
    end else if (en && pv) begin
      skid_data <= pdata;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== rtl/ccw_lane.sv =====
// one endpoint lane: leg from the contact, squared length, |leg . pen| and pipelined sqrt
// depends on ccw_pkg
module ccw_lane import ccw_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  coord_t             pt   [3],
  input  coord_t             ctr  [3],
  input  coord_t             pen  [3],
  output logic [LEN_W-1:0]   len,
  output logic [DOT_W-1:0]   absdot
);

  logic signed [LEG_W-1:0] leg_a [3];
  coord_t                  pen_a [3];
  logic [LEG_W-1:0]        ml_b  [3];
  logic [PEN_W-1:0]        mp_b  [3];
  logic                    sg_b  [3];
  logic [SQ_W-1:0]         sq_c  [3];
  logic [DOT_W-1:0]        pr_c  [3];
  logic                    sg_c  [3];
  logic [SQ_W-1:0]         sq_d;
  logic [DOT_W-1:0]        pos_d;
  logic [DOT_W-1:0]        neg_d;
  logic [SQ_W-1:0]         sq_e;
  logic [DOT_W-1:0]        dot_e;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        leg_a[k] <= {pt[k][COORD_W-1], pt[k]} - {ctr[k][COORD_W-1], ctr[k]};
        pen_a[k] <= pen[k];
        ml_b[k]  <= leg_a[k][LEG_W-1] ? LEG_W'(-leg_a[k]) : LEG_W'(leg_a[k]);
        mp_b[k]  <= pen_a[k][COORD_W-1] ? PEN_W'(-pen_a[k]) : PEN_W'(pen_a[k]);
        sg_b[k]  <= leg_a[k][LEG_W-1] ^ pen_a[k][COORD_W-1];
        sq_c[k]  <= ml_b[k] * ml_b[k];
        pr_c[k]  <= ml_b[k] * mp_b[k];
        sg_c[k]  <= sg_b[k];
      end
      sq_d  <= sq_c[0] + sq_c[1] + sq_c[2];
      pos_d <= (sg_c[0] ? '0 : pr_c[0]) + (sg_c[1] ? '0 : pr_c[1]) + (sg_c[2] ? '0 : pr_c[2]);
      neg_d <= (sg_c[0] ? pr_c[0] : '0) + (sg_c[1] ? pr_c[1] : '0) + (sg_c[2] ? pr_c[2] : '0);
      sq_e  <= sq_d;
      dot_e <= (pos_d >= neg_d) ? (pos_d - neg_d) : (neg_d - pos_d);
    end
  end

  // digit-by-digit square root, one result bit per stage
  logic [SQRT_REM_W-1:0] rem_s  [LEN_W+1];
  logic [LEN_W-1:0]      root_s [LEN_W+1];
  logic [SQ_W-1:0]       rad_s  [LEN_W+1];
  logic [DOT_W-1:0]      dot_s  [LEN_W+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = sq_e;
  assign dot_s[0]  = dot_e;

  for (genvar g = 0; g < LEN_W; g++) begin : g_sqrt
    localparam int P = 2 * (LEN_W - 1 - g);
    logic [SQRT_REM_W-1:0] r;
    logic [SQRT_REM_W-1:0] trial;
    logic [SQRT_REM_W-1:0] rem_n;
    logic [LEN_W-1:0]      root_n;

    always_comb begin
      r     = {rem_s[g][SQRT_REM_W-3:0], rad_s[g][P+1:P]};
      trial = SQRT_REM_W'({root_s[g], 2'b01});
      if (r >= trial) begin
        rem_n  = r - trial;
        root_n = {root_s[g][LEN_W-2:0], 1'b1};
      end else begin
        rem_n  = r;
        root_n = {root_s[g][LEN_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1]  <= rem_n;
        root_s[g+1] <= root_n;
        rad_s[g+1]  <= rad_s[g];
        dot_s[g+1]  <= dot_s[g];
      end
    end
  end

  assign len    = root_s[LEN_W];
  assign absdot = dot_s[LEN_W];

endmodule

// ===== rtl/ccw_rawdiv.sv =====
// raw weight of one endpoint: |dot| * other length / (own length + eps), pipelined divider
// depends on ccw_pkg
module ccw_rawdiv import ccw_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [DOT_W-1:0]   absdot,
  input  logic [LEN_W-1:0]   other_len,
  input  logic [LEN_W-1:0]   own_len,
  input  logic [EPS_W-1:0]   eps,
  output logic [RAW_W-1:0]   raw
);

  logic [DOT_W-1:0]      plo;
  logic [SQ_W-1:0]       phi;
  logic [DIV_W-1:0]      dv1;
  logic [RAW_W-1:0]      num;
  logic [DIV_W-1:0]      dv2;

  // product split into two registered partial products, which are then summed into num
  always_ff @(posedge clk) begin
    if (en) begin
      plo <= absdot[31:0] * other_len;
      phi <= absdot[DOT_W-1:32] * other_len;
      dv1 <= DIV_W'(own_len) + DIV_W'(eps);
      num <= RAW_W'(plo) + {phi, 32'b0};
      dv2 <= dv1;
    end
  end

  logic [DREM_W-1:0] rem_d [RAW_W+1];
  logic [RAW_W-1:0]  nq_d  [RAW_W+1];
  logic [DIV_W-1:0]  dv_d  [RAW_W+1];

  assign rem_d[0] = '0;
  assign nq_d[0]  = num;
  assign dv_d[0]  = dv2;

  // numerator bits shift out the top while quotient bits shift in
  for (genvar g = 0; g < RAW_W; g++) begin : g_div
    logic [DREM_W-1:0] r;
    logic [DREM_W-1:0] rem_n;
    logic              q;

    always_comb begin
      r = {rem_d[g][DREM_W-2:0], nq_d[g][RAW_W-1]};
      q = (r >= DREM_W'(dv_d[g]));
      rem_n = q ? (r - DREM_W'(dv_d[g])) : r;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_d[g+1] <= rem_n;
        nq_d[g+1]  <= {nq_d[g][RAW_W-2:0], q};
        dv_d[g+1]  <= dv_d[g];
      end
    end
  end

  // zero leg with zero eps gives a zero weight
  assign raw = (dv_d[RAW_W] == '0) ? '0 : nq_d[RAW_W];

endmodule

// ===== rtl/ccw_normdiv.sv =====
// normalizing divider: floor(num * 2^FRAC_BITS / den) for num <= den, one bit per stage
// depends on ccw_pkg
module ccw_normdiv import ccw_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [RAW_W-1:0]   num,
  input  logic [RAW_W-1:0]   den,
  output logic [WGT_W-1:0]   quo
);

  logic [NREM_W-1:0] rem_n [WGT_W+1];
  logic [RAW_W-1:0]  den_n [WGT_W+1];
  logic [WGT_W-1:0]  q_n   [WGT_W+1];

  assign rem_n[0] = NREM_W'(num);
  assign den_n[0] = den;
  assign q_n[0]   = '0;

  for (genvar g = 0; g < WGT_W; g++) begin : g_step
    logic [NREM_W-1:0] r;
    logic [NREM_W-1:0] rn;
    logic              q;

    always_comb begin
      if (g == 0) begin
        r = rem_n[g];
      end else begin
        r = {rem_n[g][NREM_W-2:0], 1'b0};
      end
      q  = (r >= NREM_W'(den_n[g]));
      rn = q ? (r - NREM_W'(den_n[g])) : r;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_n[g+1] <= rn;
        den_n[g+1] <= den_n[g];
        q_n[g+1]   <= {q_n[g][WGT_W-2:0], q};
      end
    end
  end

  assign quo = q_n[WGT_W];

endmodule

// ===== rtl/ccw_merge.sv =====
// merging stage: larger raw weight, threshold test, normalization and effective mass
// depends on ccw_pkg and ccw_normdiv
module ccw_merge import ccw_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [RAW_W-1:0]     cs,
  input  logic [RAW_W-1:0]     ce,
  input  logic [EPS_W-1:0]     eps,
  input  logic [MASSIN_W-1:0]  start_mass,
  input  logic [MASSIN_W-1:0]  end_mass,
  output logic [WGT_W-1:0]     start_weight,
  output logic [WGT_W-1:0]     end_weight,
  output logic [MASS_W-1:0]    effective_mass
);

  logic [RAW_W-1:0]   cs1;
  logic [RAW_W-1:0]   ce1;
  logic [RAW_W-1:0]   mx1;
  logic [RAW_W-1:0]   thr;
  logic [WGT_W:0]     use_d;
  logic [WGT_W-1:0]   qs;
  logic [WGT_W-1:0]   qe;
  logic [WGT_W-1:0]   ws3;
  logic [WGT_W-1:0]   we3;
  logic [MPROD_W-1:0] ms4;
  logic [MPROD_W-1:0] me4;
  logic [WGT_W-1:0]   ws4;
  logic [WGT_W-1:0]   we4;
  logic [MSUM_W-1:0]  msum;
  logic [MSUM_W-FRAC_BITS-1:0] mfull;

  assign thr = RAW_W'({eps, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      cs1   <= cs;
      ce1   <= ce;
      mx1   <= (cs < ce) ? ce : cs;
      use_d <= {use_d[WGT_W-1:0], (thr < cs) || (thr < ce)};
    end
  end

  ccw_normdiv u_norm_s (.clk(clk), .en(en), .num(cs1), .den(mx1), .quo(qs));
  ccw_normdiv u_norm_e (.clk(clk), .en(en), .num(ce1), .den(mx1), .quo(qe));

  assign msum  = MSUM_W'(ms4) + MSUM_W'(me4);
  assign mfull = msum[MSUM_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      // use flag left the shift line together with the quotients
      ws3 <= use_d[WGT_W] ? qs : WGT_ONE;
      we3 <= use_d[WGT_W] ? qe : WGT_ONE;
      ms4 <= ws3 * start_mass;
      me4 <= we3 * end_mass;
      ws4 <= ws3;
      we4 <= we3;
      start_weight   <= ws4;
      end_weight     <= we4;
      effective_mass <= (mfull > (MSUM_W-FRAC_BITS)'(MASS_MAX)) ? MASS_MAX : mfull[MASS_W-1:0];
    end
  end

endmodule
